>>> sv/bb3_pkg.sv
// Shared types and constants of the 3x3 box blur core.
// Used by the core, control, window and divide modules; depends on nothing.
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int CH_W       = 8;              // one color channel
    localparam int PIX_W      = 3 * CH_W;       // packed red, green, blue
    localparam int FW_W       = 11;             // frame_width register
    localparam int FH_W       = 12;             // frame_height register
    localparam int ROW_W      = FH_W + 1;       // row counter reaches height + 1
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int SUM_W      = 12;             // nine channels of 255 at most
    localparam int PROD_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd800;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 12'd600;

    // Division by 9 as a multiply by ceil(2^15 / 9); exact for sums below 2304.
    localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
    localparam int               DIV9_SHIFT = 15;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Position of the result belonging to the current beat, and which window
    // rows and columns lie inside the frame.
    typedef struct packed {
        logic emit;
        logic last;
        logic pix_on;     // incoming row is a real frame row
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
    } pos_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sum_t;

endpackage

>>> sv/box_blur_3x3_rgb_core.sv
// 3x3 box blur core: a result passes the read stage, sum stage and divide
// stage after the beat that completes its window; results trail the input by
// one line plus one pixel in raster order. Throughput is one pixel per clock
// unless the output stalls, set by one read and one write per line store per
// pixel. Reset (rst_n low, asynchronous) clears counters and pipe valid bits
// and restores 800 x 600; line stores are not cleared.
`timescale 1ns / 1ps

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // in_red, in_green, in_blue
    input  logic [0:0]                     s_axis_tuser,  // kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                           m_axis_tlast   // last_of_frame
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CH = bb3_pkg::CH_W;

    logic               accept;
    logic [AW-1:0]      col;
    bb3_pkg::pos_t      pos;
    logic               div_ready;
    logic               sum_valid;
    bb3_pkg::sum_t      sum;
    logic               sum_last;

    assign accept = s_axis_tvalid && s_axis_tready;

    bb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .col       (col),
        .pos       (pos)
    );

    bb3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (accept),
        .in_addr   (col),
        .in_kind   (s_axis_tuser[0]),
        .in_rgb    ({s_axis_tdata[CH-1:0], s_axis_tdata[2*CH-1:CH],
                     s_axis_tdata[3*CH-1:2*CH]}),
        .in_pos    (pos),
        .in_ready  (s_axis_tready),
        .sum_ready (div_ready),
        .sum_valid (sum_valid),
        .sum       (sum),
        .sum_last  (sum_last)
    );

    bb3_div9 u_div9 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (div_ready),
        .in_sum    (sum),
        .in_last   (sum_last),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> sv/bb3_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps

module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bb3_ctrl.sv
// Frame geometry registers and the raster position counters.
// Produces the line store address and edge flags per beat; uses bb3_pkg.
`timescale 1ns / 1ps

module bb3_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             accept,
    output logic [$clog2(MAX_WIDTH)-1:0]     col,
    output bb3_pkg::pos_t                    pos
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CW   = (WW > bb3_pkg::FW_W) ? WW : bb3_pkg::FW_W;
    localparam int RW   = bb3_pkg::ROW_W;

    logic [bb3_pkg::FW_W-1:0] fw_reg;
    logic [bb3_pkg::FH_W-1:0] fh_reg;
    logic [AW-1:0]            col_reg, col_next;
    logic [RW-1:0]            row_reg, row_next;

    logic [CW-1:0] fw_ext;
    logic [CW-1:0] used_w;
    logic [RW-1:0] used_h;
    logic [RW-1:0] h_p1;
    logic [RW-1:0] row;
    logic          col_zero;
    logic          cfg_restart;

    always_comb
    begin
        fw_ext = CW'(fw_reg);
        if (fw_ext < CW'(3))
        begin
            used_w = CW'(3);
        end
        else if (fw_ext > CW'(MAX_WIDTH))
        begin
            used_w = CW'(MAX_WIDTH);
        end
        else
        begin
            used_w = fw_ext;
        end
        used_h = (fh_reg < bb3_pkg::FH_W'(3)) ? RW'(3) : RW'(fh_reg);
        h_p1   = used_h + RW'(1);
    end

    // Counters left beyond a narrowed frame fold back to the origin.
    assign col      = (CW'(col_reg) >= used_w) ? '0 : col_reg;
    assign row      = (row_reg >= used_h + RW'(2)) ? '0 : row_reg;
    assign col_zero = (col == '0);

    // At column zero the result belongs to the last column of the line before.
    always_comb
    begin
        pos.emit      = col_zero ? (row >= RW'(2) && row <= h_p1)
                                 : (row >= RW'(1) && row <= used_h);
        pos.last      = col_zero && (row == h_p1);
        pos.pix_on    = (row < used_h);
        pos.row_top   = col_zero ? (row >= RW'(3)) : (row >= RW'(2));
        pos.row_bot   = col_zero ? (row != h_p1) : (row != used_h);
        pos.col_left  = col_zero || (col >= AW'(2));
        pos.col_right = !col_zero;
    end

    assign cfg_restart = cfg_we && (cfg_index == bb3_pkg::REG_FRAME_WIDTH ||
                                    cfg_index == bb3_pkg::REG_FRAME_HEIGHT);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (pos.emit && pos.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (CW'(col) + CW'(1) >= used_w)
            begin
                col_next = '0;
                row_next = row + RW'(1);
            end
            else
            begin
                col_next = col + AW'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg  <= bb3_pkg::FRAME_WIDTH_RESET;
            fh_reg  <= bb3_pkg::FRAME_HEIGHT_RESET;
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == bb3_pkg::REG_FRAME_WIDTH)
            begin
                fw_reg <= cfg_data[bb3_pkg::FW_W-1:0];
            end
            if (cfg_we && cfg_index == bb3_pkg::REG_FRAME_HEIGHT)
            begin
                fh_reg <= cfg_data[bb3_pkg::FH_W-1:0];
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

>>> sv/bb3_window.sv
// Line stores, the sliding 3x3 window and the masked neighborhood sums.
// Holds the read stage and the sum stage of the pipe; uses bb3_pkg and bb3_ram.
`timescale 1ns / 1ps

module bb3_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [$clog2(MAX_WIDTH)-1:0]   in_addr,
    input  logic                           in_kind,
    input  logic [bb3_pkg::PIX_W-1:0]      in_rgb,
    input  bb3_pkg::pos_t                  in_pos,
    output logic                           in_ready,
    input  logic                           sum_ready,
    output logic                           sum_valid,
    output bb3_pkg::sum_t                  sum,
    output logic                           sum_last
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PW = bb3_pkg::PIX_W;
    localparam int CH = bb3_pkg::CH_W;
    localparam int SW = bb3_pkg::SUM_W;

    logic                 s1_valid_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [PW-1:0]        s1_px_reg;
    bb3_pkg::pos_t        s1_pos_reg;
    logic                 s2_valid_reg;
    bb3_pkg::sum_t        s2_sum_reg;
    logic                 s2_last_reg;

    // Two most recent window columns per row; the third column is the fresh read.
    logic [PW-1:0]        win_reg [3][2];

    logic [PW-1:0]        up_rd, lo_rd;
    logic [PW-1:0]        fresh [3];
    logic                 s2_ready;
    logic                 s1_go;
    logic [SW-1:0]        acc_r, acc_g, acc_b;
    logic                 row_on;
    logic [PW-1:0]        t0, t1, t2;

    assign s2_ready = !s2_valid_reg || sum_ready;
    assign s1_go    = s1_valid_reg && s2_ready;
    assign in_ready = !s1_valid_reg || s1_go;

    // Write-back of a beat and the read of the next one hit different entries,
    // as a line is at least three pixels long, except at column zero right after
    // a frame end. That read returns the older contents, which only feed rows
    // above the new frame, and the edge masks drop them.
    bb3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (lo_rd),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (up_rd)
    );

    bb3_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_WIDTH)
    ) u_lower (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata (s1_px_reg),
        .re    (in_fire),
        .raddr (in_addr),
        .rdata (lo_rd)
    );

    assign fresh[0] = up_rd;
    assign fresh[1] = lo_rd;
    assign fresh[2] = s1_px_reg;

    always_comb
    begin
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        for (int r = 0; r < 3; r++)
        begin
            row_on = (r == 0) ? s1_pos_reg.row_top :
                     (r == 2) ? s1_pos_reg.row_bot : 1'b1;
            t0 = (row_on && s1_pos_reg.col_left)  ? win_reg[r][0] : '0;
            t1 = row_on                           ? win_reg[r][1] : '0;
            t2 = (row_on && s1_pos_reg.col_right) ? fresh[r]      : '0;
            acc_r = acc_r + SW'(t0[3*CH-1:2*CH]) + SW'(t1[3*CH-1:2*CH])
                          + SW'(t2[3*CH-1:2*CH]);
            acc_g = acc_g + SW'(t0[2*CH-1:CH]) + SW'(t1[2*CH-1:CH])
                          + SW'(t2[2*CH-1:CH]);
            acc_b = acc_b + SW'(t0[CH-1:0]) + SW'(t1[CH-1:0]) + SW'(t2[CH-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= '0;
                win_reg[r][1] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_fire;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_go && s1_pos_reg.emit;
            end
            if (s1_go)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= fresh[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_addr_reg <= in_addr;
            s1_px_reg   <= (!in_kind && in_pos.pix_on) ? in_rgb : '0;
            s1_pos_reg  <= in_pos;
        end
        if (s1_go)
        begin
            s2_sum_reg.red   <= acc_r;
            s2_sum_reg.green <= acc_g;
            s2_sum_reg.blue  <= acc_b;
            s2_last_reg      <= s1_pos_reg.last;
        end
    end

    assign sum_valid = s2_valid_reg;
    assign sum       = s2_sum_reg;
    assign sum_last  = s2_last_reg;

endmodule

>>> sv/bb3_div9.sv
// Divides the three channel sums by nine and holds the outgoing beat.
// Output register stage of the pipe; uses bb3_pkg.
`timescale 1ns / 1ps

module bb3_div9 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bb3_pkg::sum_t                 in_sum,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4*bb3_pkg::CH_W-1:0]    out_data,
    output logic                          out_last
);

    localparam int CH = bb3_pkg::CH_W;
    localparam int PW = bb3_pkg::PROD_W;
    localparam int SH = bb3_pkg::DIV9_SHIFT;

    logic              valid_reg;
    logic [4*CH-1:0]   data_reg;
    logic              last_reg;
    logic [PW-1:0]     prod_r, prod_g, prod_b;

    assign in_ready = !valid_reg || out_ready;

    assign prod_r = PW'(in_sum.red)   * PW'(bb3_pkg::DIV9_MUL);
    assign prod_g = PW'(in_sum.green) * PW'(bb3_pkg::DIV9_MUL);
    assign prod_b = PW'(in_sum.blue)  * PW'(bb3_pkg::DIV9_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= {bb3_pkg::ALPHA_OPAQUE,
                         prod_b[SH+CH-1:SH],
                         prod_g[SH+CH-1:SH],
                         prod_r[SH+CH-1:SH]};
            last_reg <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

>>> sv/bb3_checker.sv
// Port-level checks for the 3x3 box blur core, bound to the top level.
// Sees only the top-level ports; uses nothing else.
`timescale 1ns / 1ps

module bb3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

    // Every result is opaque.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:24] == 8'hFF)
    else $error("output alpha is not opaque");

    // With the output register empty nothing inside may hold the input back.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

    // Coming out of reset the pipe holds no result.
    assert property (@(posedge clk)
        $past(!rst_n) |-> !m_axis_tvalid)
    else $error("result present right after reset");

endmodule

bind box_blur_3x3_rgb_core bb3_checker u_bb3_checker (.*);
